// File: sv/alw_pkg.sv
// ----------------------------------------------------------------------------
// alw_pkg
// Shared types, sizes and codes of the antialiased line accumulator.
// ----------------------------------------------------------------------------
package alw_pkg;

  // Grid geometry and cell format
  localparam int MAX_COLS  = 256;
  localparam int MAX_ROWS  = 256;
  localparam int FRAC_BITS = 8;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int ADDR_W    = COL_W + ROW_W;
  localparam int DEPTH     = MAX_COLS * MAX_ROWS;

  // Fixed point constants (Q16)
  localparam int ONE_Q16  = 65536;
  localparam int HALF_Q16 = 32768;

  // Datapath widths
  localparam int PW    = 41;            // pixel coordinate, signed Q16
  localparam int DW    = 42;            // coordinate difference
  localparam int NW    = DW + 16;       // divider numerator
  localparam int QW    = 17;            // gradient magnitude
  localparam int GW    = QW + 1;        // signed gradient
  localparam int YW    = 42;            // endpoint intercept, signed Q16
  localparam int CW    = 34;            // signed cell coordinate
  localparam int OFF_W = 27;            // span start offset
  localparam int IYW   = 48;            // span intercept, signed Q16
  localparam int WW    = FRAC_BITS + 1; // coverage weight

  // Operation codes
  localparam logic [1:0] OP_SEGMENT = 2'd0;
  localparam logic [1:0] OP_POINT   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Register indexes
  localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] CFG_SCALE_X     = 3'd2;
  localparam logic [2:0] CFG_SCALE_Y     = 3'd3;
  localparam logic [2:0] CFG_GRID_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_GRID_HEIGHT = 3'd5;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by_coord;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } in_t;

  typedef struct packed {
    logic [31:0] cell_value;
    logic        in_grid;
  } out_t;

endpackage

// File: sv/alw_div.sv
// ----------------------------------------------------------------------------
// alw_div
// Restoring divider for the line gradient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alw_div
  import alw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NW-1:0]     num_i,
  input  logic [DW-1:0]     den_i,
  output logic              busy_o,
  output logic [QW-1:0]     quo_o
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [DW:0]      rem_q, rem_d, rem_sh;
  logic [DW-1:0]    den_q;
  logic [QW-1:0]    low_q, quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             take;

  // Quotient fits in QW bits, so the upper numerator bits start below den.
  assign rem_sh = {rem_q[DW-1:0], low_q[QW-1]};
  assign take   = rem_sh >= {1'b0, den_q};
  assign rem_d  = take ? rem_sh - {1'b0, den_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QW);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= cnt_q != CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= (DW+1)'(num_i[NW-1:QW]);
      low_q <= num_i[QW-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// File: sv/antialiased_line_accumulator.sv
// ----------------------------------------------------------------------------
// antialiased_line_accumulator
// Density grid that collects antialiased line coverage, points and reads.
// ----------------------------------------------------------------------------
// Usage
//   Items enter on in_valid_i/in_ready_o and carry an op: draw a segment,
//   draw a point or read one cell. Every item gives exactly one result item
//   on out_valid_o/out_ready_i; draws return zero with in_grid low.
//   Write registers on cfg_valid_i/cfg_ready_o only while the block idles.
//   Cells live in one single-port-write RAM with a registered read; every
//   coverage weight is a read, then a saturating add and write back.
//   The block itself does not enforce that register rule. Each walked column
//   of a segment takes two read-modify-writes; the gradient divider and the
//   RAM read-modify-write loop set the time per item. One item at a time.
//   Reset: registers take their defaults and a clearing pass writes zero to
//   all 65536 cells, one a cycle; in_ready_o stays low until it ends.
//   A stalled receiver holds the finished result in the output register;
//   the next item is still taken and waits at its end for the slot.
// ----------------------------------------------------------------------------
module antialiased_line_accumulator
  import alw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_MAP       = 5'd1;
  localparam logic [4:0] S_SETUP     = 5'd2;
  localparam logic [4:0] S_DIV_START = 5'd3;
  localparam logic [4:0] S_DIV_WAIT  = 5'd4;
  localparam logic [4:0] S_E0        = 5'd5;
  localparam logic [4:0] S_E1        = 5'd6;
  localparam logic [4:0] S_E2        = 5'd7;
  localparam logic [4:0] S_PLOT_RD   = 5'd8;
  localparam logic [4:0] S_PLOT_WR   = 5'd9;
  localparam logic [4:0] S_SPAN0     = 5'd10;
  localparam logic [4:0] S_SPAN1     = 5'd11;
  localparam logic [4:0] S_SPAN2     = 5'd12;
  localparam logic [4:0] S_SPAN_STEP = 5'd13;
  localparam logic [4:0] S_READ      = 5'd14;
  localparam logic [4:0] S_READ_WAIT = 5'd15;
  localparam logic [4:0] S_FINISH    = 5'd16;

  // Control state
  logic [4:0]        state_q, state_d, ret_q, ret_d;
  logic [1:0]        map_cnt_q, map_cnt_d;
  logic              sel_q, sel_d, end_q, end_d, steep_q, steep_d;
  logic              clr_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic              out_valid_q, out_valid_d;

  // Configuration
  logic signed [31:0] org_x_q, org_y_q;
  logic [23:0]        scl_x_q, scl_y_q;
  logic [8:0]         gw_q, gh_q;

  // Payload registers
  in_t                   item_q, item_d;
  out_t                  res_q, res_d, out_q, out_d;
  logic signed [PW-1:0]  px_q [4];
  logic signed [PW-1:0]  px_d;
  logic signed [PW-1:0]  x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic                  dy_neg_q, dy_neg_d;
  logic signed [GW-1:0]  grad_q, grad_d;
  logic signed [CW-1:0]  xend_q, xend_d, xp1_q, xp1_d, xp2_q, xp2_d;
  logic [16:0]           gap_q, gap_d;
  logic signed [34:0]    eprod_q, eprod_d;
  logic signed [YW-1:0]  yend_q, yend_d, yend1_q, yend1_d;
  logic signed [CW-1:0]  pa_q, pa_d, pb_q, pb_d;
  logic [WW-1:0]         w0_q, w0_d, w1_q, w1_d, pw_q, pw_d;
  logic [ADDR_W-1:0]     paddr_q, paddr_d;
  logic signed [CW-1:0]  x_q, x_d, hi_q, hi_d;
  logic signed [GW+OFF_W-1:0] sprod_q, sprod_d;
  logic signed [IYW-1:0] iy_q, iy_d;

  // Memory ports
  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr, plot_addr, read_addr;
  logic [31:0]       mem_wdata;

  // Divider
  logic              div_start, div_busy;
  logic [NW-1:0]     div_num;
  logic [DW-1:0]     div_den;
  logic [QW-1:0]     div_quo;

  // Combinational datapath
  logic signed [31:0]    m_w, m_org;
  logic [23:0]           m_scl;
  logic signed [32:0]    m_diff;
  logic signed [57:0]    m_prod;
  logic signed [DW-1:0]  adx, ady, dx, dy;
  logic                  steep_c;
  logic signed [PW-1:0]  sx0, sy0, sx1, sy1;
  logic signed [PW-1:0]  xe, ye;
  logic signed [PW:0]    e_s;
  logic signed [16:0]    e_d;
  logic [16:0]           rf;
  logic [33:0]           p0, p1;
  logic signed [CW-1:0]  cols_used, rows_used, lim;
  logic signed [CW-1:0]  lo_c, lo, hi_c, hi, offs_c;
  logic signed [CW-1:0]  pb_sel, col_c, row_c;
  logic                  plot_in, read_in;
  logic [16:0]           span_rf;
  logic [32:0]           sum;

  alw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // Map world to pixel space: one shared multiplier, one coordinate a cycle.
  always_comb begin
    case (map_cnt_q)
      2'd0:    begin m_w = item_q.ax;       m_org = org_x_q; m_scl = scl_x_q; end
      2'd1:    begin m_w = item_q.ay;       m_org = org_y_q; m_scl = scl_y_q; end
      2'd2:    begin m_w = item_q.bx;       m_org = org_x_q; m_scl = scl_x_q; end
      default: begin m_w = item_q.by_coord; m_org = org_y_q; m_scl = scl_y_q; end
    endcase
  end
  assign m_diff = 33'(m_w) - 33'(m_org);
  assign m_prod = m_diff * $signed({1'b0, m_scl});
  assign px_d   = $signed(m_prod[56:16]);

  // Steep test and swaps
  assign adx     = (px_q[2] > px_q[0]) ? DW'(px_q[2]) - DW'(px_q[0])
                                       : DW'(px_q[0]) - DW'(px_q[2]);
  assign ady     = (px_q[3] > px_q[1]) ? DW'(px_q[3]) - DW'(px_q[1])
                                       : DW'(px_q[1]) - DW'(px_q[3]);
  assign steep_c = ady > adx;
  assign sx0     = steep_c ? px_q[1] : px_q[0];
  assign sy0     = steep_c ? px_q[0] : px_q[1];
  assign sx1     = steep_c ? px_q[3] : px_q[2];
  assign sy1     = steep_c ? px_q[2] : px_q[3];

  assign dx      = DW'(x1_q) - DW'(x0_q);
  assign dy      = DW'(y1_q) - DW'(y0_q);
  assign div_num = {(dy < 0) ? DW'(-dy) : DW'(dy), 16'd0};
  assign div_den = dx;

  // Endpoint arithmetic
  assign xe  = end_q ? x1_q : x0_q;
  assign ye  = end_q ? y1_q : y0_q;
  assign e_s = (PW+1)'(xe) + (PW+1)'(HALF_Q16);
  assign e_d = $signed(17'(HALF_Q16) - {1'b0, e_s[15:0]});
  assign rf  = 17'(ONE_Q16) - {1'b0, yend_q[15:0]};
  assign p0  = 34'(rf) * 34'(gap_q);
  assign p1  = 34'(yend_q[15:0]) * 34'(gap_q);

  // Grid bounds
  assign cols_used = (gw_q > 9'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(gw_q);
  assign rows_used = (gh_q > 9'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(gh_q);
  assign lim       = steep_q ? rows_used : cols_used;

  // Span limits: walk only columns that can land in the grid
  assign lo_c   = xp1_q + CW'(1);
  assign lo     = (lo_c < 0) ? '0 : lo_c;
  assign hi_c   = xp2_q - CW'(1);
  assign hi     = (hi_c > lim - CW'(1)) ? lim - CW'(1) : hi_c;
  assign offs_c = lo - xp1_q - CW'(1);
  assign span_rf = 17'(ONE_Q16) - {1'b0, iy_q[15:0]};

  // Plot address and grid test
  assign pb_sel  = pb_q + CW'(sel_q);
  assign col_c   = steep_q ? pb_sel : pa_q;
  assign row_c   = steep_q ? pa_q : pb_sel;
  assign plot_in = (col_c >= 0) && (col_c < cols_used) &&
                   (row_c >= 0) && (row_c < rows_used);
  assign plot_addr = {row_c[ROW_W-1:0], col_c[COL_W-1:0]};
  assign read_in   = (CW'(item_q.read_col) < cols_used) &&
                     (CW'(item_q.read_row) < rows_used);
  assign read_addr = {ROW_W'(item_q.read_row), COL_W'(item_q.read_col)};

  // Saturating accumulate
  assign sum = {1'b0, rdata_q} + 33'(pw_q);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    map_cnt_d   = map_cnt_q;
    sel_d       = sel_q;
    end_d       = end_q;
    steep_d     = steep_q;
    out_valid_d = out_valid_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    x0_d = x0_q; y0_d = y0_q; x1_d = x1_q; y1_d = y1_q;
    dy_neg_d    = dy_neg_q;
    grad_d      = grad_q;
    xend_d      = xend_q;
    gap_d       = gap_q;
    eprod_d     = eprod_q;
    yend_d      = yend_q;
    yend1_d     = yend1_q;
    xp1_d       = xp1_q;
    xp2_d       = xp2_q;
    pa_d = pa_q; pb_d = pb_q; w0_d = w0_q; w1_d = w1_q; pw_d = pw_q;
    paddr_d     = paddr_q;
    x_d         = x_q;
    hi_d        = hi_q;
    sprod_d     = sprod_q;
    iy_d        = iy_q;
    div_start   = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = plot_addr;

    // Drop the result once taken
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !clr_q) begin
          item_d    = in_item_i;
          res_d     = '0;
          map_cnt_d = '0;
          if (in_item_i.op == OP_SEGMENT || in_item_i.op == OP_POINT) begin
            state_d = S_MAP;
          end else if (in_item_i.op == OP_READ) begin
            state_d = S_READ;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_MAP: begin
        map_cnt_d = map_cnt_q + 2'd1;
        if (map_cnt_q == 2'd3) begin
          if (item_q.op == OP_SEGMENT) begin
            state_d = S_SETUP;
          end else begin
            // Point: whole-pixel cell, second plot of the pair adds nothing
            steep_d = 1'b0;
            pa_d    = CW'($signed(px_q[0][PW-1:16]));
            pb_d    = CW'($signed(px_q[1][PW-1:16]));
            w0_d    = WW'(1 << FRAC_BITS);
            w1_d    = '0;
            sel_d   = 1'b0;
            ret_d   = S_FINISH;
            state_d = S_PLOT_RD;
          end
        end
      end
      S_SETUP: begin
        steep_d = steep_c;
        end_d   = 1'b0;
        if (sx0 > sx1) begin
          x0_d = sx1; y0_d = sy1; x1_d = sx0; y1_d = sy0;
        end else begin
          x0_d = sx0; y0_d = sy0; x1_d = sx1; y1_d = sy1;
        end
        state_d = S_DIV_START;
      end
      S_DIV_START: begin
        dy_neg_d = dy < 0;
        if (dx == '0) begin
          grad_d  = GW'(ONE_Q16);
          state_d = S_E0;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (!div_busy) begin
          grad_d  = dy_neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
          state_d = S_E0;
        end
      end
      S_E0: begin
        xend_d  = CW'($signed(e_s[PW:16]));
        gap_d   = end_q ? {1'b0, e_s[15:0]} : 17'(ONE_Q16) - {1'b0, e_s[15:0]};
        eprod_d = grad_q * e_d;
        state_d = S_E1;
      end
      S_E1: begin
        yend_d  = YW'(ye) + YW'($signed(eprod_q[34:16]));
        state_d = S_E2;
      end
      S_E2: begin
        pa_d  = xend_q;
        pb_d  = CW'($signed(yend_q[YW-1:16]));
        w0_d  = WW'(p0 >> (32 - FRAC_BITS));
        w1_d  = WW'(p1 >> (32 - FRAC_BITS));
        sel_d = 1'b0;
        if (!end_q) begin
          xp1_d   = xend_q;
          yend1_d = yend_q;
          end_d   = 1'b1;
          ret_d   = S_E0;
        end else begin
          xp2_d = xend_q;
          ret_d = S_SPAN0;
        end
        state_d = S_PLOT_RD;
      end
      S_PLOT_RD: begin
        if (plot_in) begin
          mem_re  = 1'b1;
          paddr_d = plot_addr;
          pw_d    = sel_q ? w1_q : w0_q;
          state_d = S_PLOT_WR;
        end else if (!sel_q) begin
          sel_d = 1'b1;
        end else begin
          sel_d   = 1'b0;
          state_d = ret_q;
        end
      end
      S_PLOT_WR: begin
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = S_PLOT_RD;
        end else begin
          sel_d   = 1'b0;
          state_d = ret_q;
        end
      end
      S_SPAN0: begin
        if (lo > hi) begin
          state_d = S_FINISH;
        end else begin
          x_d     = lo;
          hi_d    = hi;
          sprod_d = grad_q * $signed(OFF_W'(offs_c));
          state_d = S_SPAN1;
        end
      end
      S_SPAN1: begin
        iy_d    = IYW'(yend1_q) + IYW'(grad_q) + IYW'(sprod_q);
        state_d = S_SPAN2;
      end
      S_SPAN2: begin
        pa_d    = x_q;
        pb_d    = CW'($signed(iy_q[IYW-1:16]));
        w0_d    = WW'(span_rf >> (16 - FRAC_BITS));
        w1_d    = WW'(iy_q[15:0] >> (16 - FRAC_BITS));
        sel_d   = 1'b0;
        ret_d   = S_SPAN_STEP;
        state_d = S_PLOT_RD;
      end
      S_SPAN_STEP: begin
        if (x_q == hi_q) begin
          state_d = S_FINISH;
        end else begin
          x_d     = x_q + CW'(1);
          iy_d    = iy_q + IYW'(grad_q);
          state_d = S_SPAN2;
        end
      end
      S_READ: begin
        if (read_in) begin
          mem_re    = 1'b1;
          mem_raddr = read_addr;
          state_d   = S_READ_WAIT;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_READ_WAIT: begin
        res_d.cell_value = rdata_q;
        res_d.in_grid    = 1'b1;
        state_d          = S_FINISH;
      end
      S_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Write port: clearing pass after reset, else plot write back
  assign mem_we    = clr_q || (state_q == S_PLOT_WR);
  assign mem_waddr = clr_q ? clr_cnt_q : paddr_q;
  assign mem_wdata = clr_q ? 32'd0 : (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      map_cnt_q   <= '0;
      sel_q       <= 1'b0;
      end_q       <= 1'b0;
      steep_q     <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      org_x_q     <= '0;
      org_y_q     <= '0;
      scl_x_q     <= 24'(ONE_Q16);
      scl_y_q     <= 24'(ONE_Q16);
      gw_q        <= 9'(MAX_COLS);
      gh_q        <= 9'(MAX_ROWS);
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      map_cnt_q   <= map_cnt_d;
      sel_q       <= sel_d;
      end_q       <= end_d;
      steep_q     <= steep_d;
      out_valid_q <= out_valid_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        clr_q     <= clr_cnt_q != ADDR_W'(DEPTH - 1);
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ORIGIN_X:    org_x_q <= cfg_data_i;
          CFG_ORIGIN_Y:    org_y_q <= cfg_data_i;
          CFG_SCALE_X:     scl_x_q <= cfg_data_i[23:0];
          CFG_SCALE_Y:     scl_y_q <= cfg_data_i[23:0];
          CFG_GRID_WIDTH:  gw_q    <= cfg_data_i[8:0];
          CFG_GRID_HEIGHT: gh_q    <= cfg_data_i[8:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    res_q    <= res_d;
    out_q    <= out_d;
    x0_q     <= x0_d;
    y0_q     <= y0_d;
    x1_q     <= x1_d;
    y1_q     <= y1_d;
    dy_neg_q <= dy_neg_d;
    grad_q   <= grad_d;
    xend_q   <= xend_d;
    gap_q    <= gap_d;
    eprod_q  <= eprod_d;
    yend_q   <= yend_d;
    yend1_q  <= yend1_d;
    xp1_q    <= xp1_d;
    xp2_q    <= xp2_d;
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    w0_q     <= w0_d;
    w1_q     <= w1_d;
    pw_q     <= pw_d;
    paddr_q  <= paddr_d;
    x_q      <= x_d;
    hi_q     <= hi_d;
    sprod_q  <= sprod_d;
    iy_q     <= iy_d;
    if (state_q == S_MAP) begin
      px_q[map_cnt_q] <= px_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !clr_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

// File: sv/alw_checker.sv
// ----------------------------------------------------------------------------
// alw_checker
// Port-level checks of the antialiased line accumulator.
// ----------------------------------------------------------------------------
module alw_checker
  import alw_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input in_t         in_item_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_t        out_item_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [31:0] cfg_data_i
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // A cell outside the grid, and every draw, reads as zero
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.in_grid |-> out_item_o.cell_value == 32'd0)
    else $error("nonzero value without in_grid");

  // One item at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while busy");

  // A new result follows work on an item
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without item");

endmodule

bind antialiased_line_accumulator alw_checker u_alw_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the antialiased line accumulator: a table of
// directed items, then random segment, point and read traffic under several
// register settings and idle patterns. A density grid in the bench tracks
// every coverage weight and predicts each result item.
// ----------------------------------------------------------------------------
module tb;
  import alw_pkg::*;

  localparam int LIMIT_CYCLES = 10000000;

  typedef struct {
    in_t  item;
    bit   has_want;
    out_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Bench copy of the registers and of the density grid
  longint      org_x, org_y, scl_x, scl_y, grid_w, grid_h;
  logic [31:0] density [DEPTH];

  out_t      pending_q [$];   // predicted result items, oldest first
  dir_row_t  dir_tab [$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_cycles = 0;
  longint    cycle_cnt = 0;

  antialiased_line_accumulator DUT (.*);

  always #1 clk_i = ~clk_i;

  // Give up on a hang
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: long hold-off when requested, else random stalls
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i = 1'b0;
      hold_cycles--;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
    errors++;
  endtask

  // Compare every result item against the oldest prediction
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        report("unexpected item", out_item_o, 0);
      end else begin
        want = pending_q.pop_front();
        if (out_item_o.cell_value !== want.cell_value)
          report("cell_value", out_item_o.cell_value, want.cell_value);
        if (out_item_o.in_grid !== want.in_grid)
          report("in_grid", out_item_o.in_grid, want.in_grid);
      end
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint flr16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint frac16(longint v);
    return v - (flr16(v) <<< 16);
  endfunction

  function automatic longint rfrac16(longint v);
    return 65536 - frac16(v);
  endfunction

  function automatic longint cols_on();
    return grid_w < MAX_COLS ? grid_w : MAX_COLS;
  endfunction

  function automatic longint rows_on();
    return grid_h < MAX_ROWS ? grid_h : MAX_ROWS;
  endfunction

  // Saturating add of one weight; drop weights that miss the grid
  function automatic void deposit(longint col, longint row, longint w);
    longint sum;
    int     idx;
    if (col < 0 || row < 0 || col >= cols_on() || row >= rows_on()) return;
    idx = int'(row * MAX_COLS + col);
    sum = longint'(density[idx]) + w;
    density[idx] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // a runs along the major axis; the steep case swaps back to col/row
  function automatic void deposit_ab(bit steep, longint a, longint b, longint w);
    if (steep) deposit(b, a, w);
    else deposit(a, b, w);
  endfunction

  function automatic void end_cap(bit steep, longint x, longint y, longint grad,
                                  bit first);
    longint xe, ye, gap, yp;
    xe  = flr16(x + HALF_Q16);
    ye  = y + flr16(grad * (xe * ONE_Q16 - x));
    gap = first ? rfrac16(x + HALF_Q16) : frac16(x + HALF_Q16);
    yp  = flr16(ye);
    deposit_ab(steep, xe, yp, (rfrac16(ye) * gap) >> (32 - FRAC_BITS));
    deposit_ab(steep, xe, yp + 1, (frac16(ye) * gap) >> (32 - FRAC_BITS));
  endfunction

  function automatic void wu_line(longint x0, longint y0, longint x1, longint y1);
    longint t, dx, dy, grad, xp1, xp2, ye1, iy0, lo, hi, lim, iy, yb;
    bit     steep;
    steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
    if (steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx   = x1 - x0;
    dy   = y1 - y0;
    grad = (dx == 0) ? ONE_Q16 : (dy * ONE_Q16) / dx;
    end_cap(steep, x0, y0, grad, 1'b1);
    end_cap(steep, x1, y1, grad, 1'b0);
    xp1 = flr16(x0 + HALF_Q16);
    xp2 = flr16(x1 + HALF_Q16);
    ye1 = y0 + flr16(grad * (xp1 * ONE_Q16 - x0));
    iy0 = ye1 + grad;
    lim = steep ? rows_on() : cols_on();
    lo  = (xp1 + 1 < 0) ? 0 : xp1 + 1;
    hi  = (xp2 - 1 > lim - 1) ? lim - 1 : xp2 - 1;
    // walk only the span steps that can land in the grid
    for (longint x = lo; x <= hi; x++) begin
      iy = iy0 + grad * (x - (xp1 + 1));
      yb = flr16(iy);
      deposit_ab(steep, x, yb, rfrac16(iy) >> (16 - FRAC_BITS));
      deposit_ab(steep, x, yb + 1, frac16(iy) >> (16 - FRAC_BITS));
    end
  endfunction

  function automatic longint pix_of(logic signed [31:0] w, longint org, longint scl);
    return flr16((longint'(w) - org) * scl);
  endfunction

  // Apply one item to the bench grid and return its result item
  function automatic out_t accumulate(in_t it);
    out_t r;
    r = '0;
    case (it.op)
      OP_SEGMENT: wu_line(pix_of(it.ax, org_x, scl_x), pix_of(it.ay, org_y, scl_y),
                          pix_of(it.bx, org_x, scl_x),
                          pix_of(it.by_coord, org_y, scl_y));
      OP_POINT: deposit(flr16(pix_of(it.ax, org_x, scl_x)),
                        flr16(pix_of(it.ay, org_y, scl_y)), 1 << FRAC_BITS);
      OP_READ: begin
        if (it.read_col < cols_on() && it.read_row < rows_on()) begin
          r.cell_value = density[int'(it.read_row) * MAX_COLS + int'(it.read_col)];
          r.in_grid = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------ drivers
  // Offer one item after the idle gap; predict it once accepted.
  // A typed-in result, where given, replaces the prediction in the check.
  task automatic send_item(in_t it, bit has_want, out_t want);
    out_t pred;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_item_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pred = accumulate(it);
    pending_q.push_back(has_want ? want : pred);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ORIGIN_X:    org_x  = longint'(signed'(data));
      CFG_ORIGIN_Y:    org_y  = longint'(signed'(data));
      CFG_SCALE_X:     scl_x  = data[23:0];
      CFG_SCALE_Y:     scl_y  = data[23:0];
      CFG_GRID_WIDTH:  grid_w = data[8:0];
      CFG_GRID_HEIGHT: grid_h = data[8:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Hold until every result item is back, then let the block settle
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic void add_row(logic [1:0] op, logic [31:0] ax, logic [31:0] ay,
                                  logic [31:0] bx, logic [31:0] by, int col, int row,
                                  bit has_want, logic [31:0] val, bit ing);
    dir_row_t d;
    d.item = '{op: op, ax: ax, ay: ay, bx: bx, by_coord: by,
               read_col: col[7:0], read_row: row[7:0]};
    d.has_want = has_want;
    d.want = '{cell_value: val, in_grid: ing};
    dir_tab.push_back(d);
  endfunction

  // World coordinate that lands on the given Q16 pixel position
  function automatic logic [31:0] world_of(longint pix, longint org, longint scl);
    longint w;
    if (scl == 0) return $urandom;
    w = org + (pix <<< 16) / scl;
    return w[31:0];
  endfunction

  function automatic longint rand_pix(longint span);
    return (longint'($urandom_range(int'(span) + 8)) - 4) * ONE_Q16
           + longint'($urandom_range(65535));
  endfunction

  // Mostly well-formed traffic aimed at the grid, some raw noise
  function automatic in_t rand_item();
    in_t    it;
    longint px0, py0, px1, py1, cw, ch;
    int     pick;
    cw   = cols_on() > 4 ? cols_on() : 4;
    ch   = rows_on() > 4 ? rows_on() : 4;
    pick = $urandom_range(99);
    it   = '{op: OP_READ, ax: $urandom, ay: $urandom, bx: $urandom,
             by_coord: $urandom, read_col: 8'($urandom), read_row: 8'($urandom)};
    if (pick < 6) begin
      it.op = 2'($urandom_range(3));        // noise, unused op code included
      return it;
    end
    px0 = rand_pix(cw);
    py0 = rand_pix(ch);
    if ($urandom_range(99) < 8) begin
      px1 = rand_pix(cw);                   // rare long segment
      py1 = rand_pix(ch);
    end else begin
      px1 = px0 + longint'($urandom_range(40 * 65536)) - 20 * 65536;
      py1 = py0 + longint'($urandom_range(40 * 65536)) - 20 * 65536;
    end
    it.ax       = world_of(px0, org_x, scl_x);
    it.ay       = world_of(py0, org_y, scl_y);
    it.bx       = world_of(px1, org_x, scl_x);
    it.by_coord = world_of(py1, org_y, scl_y);
    if (pick < 46) it.op = OP_SEGMENT;
    else if (pick < 68) it.op = OP_POINT;
    else begin
      it.op = OP_READ;
      if ($urandom_range(3) != 0) begin
        it.read_col = 8'($urandom_range(int'(cw) - 1));
        it.read_row = 8'($urandom_range(int'(ch) - 1));
      end
    end
    return it;
  endfunction

  // ------------------------------------------------------------------ stimulus
  initial begin
    logic [31:0] reg_val [6][6];
    int          n_items [6];
    int          send_pct [6];
    int          recv_pct [6];
    in_t         it;

    org_x = 0; org_y = 0; scl_x = 65536; scl_y = 65536; grid_w = 256; grid_h = 256;
    foreach (density[i]) density[i] = '0;

    // Registers per phase: origin x/y, scale x/y, width, height
    reg_val[0] = '{32'h0, 32'h0, 32'h10000, 32'h10000, 32'd256, 32'd256};
    reg_val[1] = '{-32'sd327680, 32'h0003_007B, 32'h20000, 32'h18000, 32'd100, 32'd37};
    reg_val[2] = '{32'h7FFF_0000, 32'h8000_0000, 32'hFF_FFFF, 32'h8000, 32'd511,
                   32'd256};
    reg_val[3] = '{32'd12345, -32'sd777, 32'h10000, 32'h30000, 32'd0, 32'd1};
    reg_val[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFF_FFFF, 32'd1, 32'd256};
    reg_val[5] = '{32'h0, 32'h0, 32'h10000, 32'h10000, 32'd256, 32'd256};
    n_items  = '{300, 250, 250, 100, 100, 100};
    send_pct = '{0, 72, 0, 34, 0, 34};
    recv_pct = '{0, 0, 72, 34, 0, 34};

    // Directed items on the reset settings: origin 0, one pixel per unit
    add_row(OP_READ, 0, 0, 0, 0, 0, 0, 1, 0, 1);             // cleared cell
    add_row(OP_READ, 0, 0, 0, 0, 255, 255, 1, 0, 1);         // far corner
    add_row(OP_POINT, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 1, 0, 0);
    add_row(OP_READ, 0, 0, 0, 0, 3, 4, 1, 256, 1);           // one point
    add_row(2'd3, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
            255, 255, 1, 0, 0);                              // unused op code
    add_row(OP_SEGMENT, 32'h0000_8000, 32'h000A_4000, 32'h0014_C000, 32'h000A_4000,
            0, 0, 1, 0, 0);                                  // flat line
    add_row(OP_READ, 0, 0, 0, 0, 10, 10, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0, 0, 10, 11, 0, 0, 0);
    add_row(OP_SEGMENT, 32'h0005_0000, 32'h0, 32'h0007_8000, 32'h001E_0000,
            0, 0, 1, 0, 0);                                  // steep line
    add_row(OP_READ, 0, 0, 0, 0, 6, 15, 0, 0, 0);
    add_row(OP_SEGMENT, 32'h0028_4CCC, 32'h0028_4CCC, 32'h0028_4CCC, 32'h0028_4CCC,
            0, 0, 1, 0, 0);                                  // degenerate line
    add_row(OP_READ, 0, 0, 0, 0, 40, 40, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0, 0, 40, 41, 0, 0, 0);
    add_row(OP_SEGMENT, -32'sd3276800, -32'sd196608, 32'h012C_0000, 32'h00C8_0000,
            0, 0, 1, 0, 0);                                  // clipped long span
    add_row(OP_READ, 0, 0, 0, 0, 100, 59, 0, 0, 0);
    add_row(OP_SEGMENT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            0, 0, 1, 0, 0);                                  // coordinate extremes
    add_row(OP_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, 0, 0);
    add_row(OP_POINT, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 1, 0, 0);
    add_row(OP_READ, 0, 0, 0, 0, 255, 0, 0, 0, 0);
    add_row(OP_SEGMENT, 32'h001E_E666, 32'h0002_1999, 32'h000A_3333, 32'h0008_B333,
            0, 0, 1, 0, 0);                                  // right to left
    add_row(OP_READ, 0, 0, 0, 0, 20, 5, 0, 0, 0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].has_want,
                                   dir_tab[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int r = 0; r < 6; r++) write_reg(r[2:0], reg_val[ph][r]);
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      // Hold off the receiver so the block backs up onto its input
      if (ph == 2) hold_cycles = 4000;
      for (int k = 0; k < n_items[ph]; k++) begin
        it = rand_item();
        send_item(it, 1'b0, '0);
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
sv/alw_pkg.sv
sv/alw_div.sv
sv/antialiased_line_accumulator.sv
sv/alw_checker.sv
tb/tb.sv
